// ===== rtl/eit_pkg.sv =====
// shared types and constants of the epipolar inlier test
package eit_pkg;

    localparam int COORD_W    = 16;
    localparam int COORD_FRAC = 4;
    localparam int INDEX_W    = 16;
    localparam int F_W        = 32;
    localparam int THRESH_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_F_PAIR_A,
        CFG_F_PAIR_B,
        CFG_F_PAIR_C,
        CFG_F_PAIR_D,
        CFG_F_LAST,
        CFG_ERROR_THRESHOLD
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] left_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] right_y;
        logic        [INDEX_W-1:0] point_index;
    } t_item;

    typedef struct packed {
        logic               is_inlier;
        logic [INDEX_W-1:0] index_out;
    } t_result;

endpackage

// ===== rtl/epipolar_inlier_test.sv =====
// top level of the epipolar inlier test pipeline
// One correspondence is taken in every clock cycle (busy stays low) and its
// verdict appears on o_result with o_strobe high for a single cycle, in the order
// of acceptance. The latency is set by the chain of 32x32 partial-product stages
// of the wide multipliers: the squared residual, its product with the sum of the
// line norms, and the scaling stages around them. Results cannot be held off, so
// the receiver must take each item in its strobe cycle. Matrix and threshold
// writes take effect at once; the user must make them only while no item is in
// flight, as the block does not enforce this.
module epipolar_inlier_test (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  eit_pkg::t_item              i_item,
    output logic                        o_strobe,
    output eit_pkg::t_result            o_result,
    input  logic                        i_cfg_we,
    input  logic [eit_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [eit_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int C   = eit_pkg::COORD_W;
    localparam int FW  = eit_pkg::F_W;
    localparam int FR  = eit_pkg::COORD_FRAC;
    localparam int PW  = FW + C;
    localparam int L   = PW + 2;
    localparam int LH  = L - 32;
    localparam int DLO = C + 33;
    localparam int DHI = C + LH;
    localparam int D   = C + L + 2;
    localparam int N   = 2 * L + 1;
    localparam int NS  = 2 * L + 2;
    localparam int NP  = 2 * N;
    localparam int D2  = 2 * D;
    localparam int LR  = D2 + NS;
    localparam int LHS = LR + 15;
    localparam int TW  = 2 * eit_pkg::THRESH_W;
    localparam int RR  = NP + TW;
    localparam int RHS = RR + 9;
    localparam int CW  = (LHS > RHS) ? LHS : RHS;

    localparam int NL  = (L + 31) / 32;
    localparam int ML  = NL * NL;
    localparam int ND  = (D + 31) / 32;
    localparam int MD  = ND * ND;
    localparam int NN  = (N + 31) / 32;
    localparam int MN  = NN * NN;
    localparam int MLR = ((D2 + 31) / 32) * ((NS + 31) / 32);
    localparam int MRR = ((NP + 31) / 32) * ((TW + 31) / 32);

    localparam int TN  = 4 + ML;
    localparam int TD2 = 5 + MD;
    localparam int TJ  = (TD2 > TN + 1) ? TD2 : TN + 1;
    localparam int TL  = TJ + MLR + 1;
    localparam int TR  = TN + MN + MRR + 1;
    localparam int TC  = (TL > TR) ? TL : TR;
    localparam int LAT = TC + 1;

    // configuration registers
    logic [eit_pkg::CFG_DATA_W-1:0] r_f_pair [4];
    logic [FW-1:0]                  r_f_last;
    logic [eit_pkg::THRESH_W-1:0]   r_thresh;
    logic [TW-1:0]                  r_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_pair <= '{default: '0};
            r_f_last <= '0;
            r_thresh <= eit_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                eit_pkg::CFG_F_PAIR_A: r_f_pair[0] <= i_cfg_data;
                eit_pkg::CFG_F_PAIR_B: r_f_pair[1] <= i_cfg_data;
                eit_pkg::CFG_F_PAIR_C: r_f_pair[2] <= i_cfg_data;
                eit_pkg::CFG_F_PAIR_D: r_f_pair[3] <= i_cfg_data;
                eit_pkg::CFG_F_LAST: r_f_last <= i_cfg_data[FW-1:0];
                eit_pkg::CFG_ERROR_THRESHOLD: r_thresh <= i_cfg_data[eit_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_t2 <= TW'(r_thresh) * TW'(r_thresh);
    end

    logic signed [FW-1:0] w_f [3][3];
    assign w_f[0][0] = r_f_pair[0][31:0];
    assign w_f[0][1] = r_f_pair[0][63:32];
    assign w_f[0][2] = r_f_pair[1][31:0];
    assign w_f[1][0] = r_f_pair[1][63:32];
    assign w_f[1][1] = r_f_pair[2][31:0];
    assign w_f[1][2] = r_f_pair[2][63:32];
    assign w_f[2][0] = r_f_pair[3][31:0];
    assign w_f[2][1] = r_f_pair[3][63:32];
    assign w_f[2][2] = r_f_last;

    // handshake and valid chain
    logic           w_accept;
    logic [LAT:1]   r_vld;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], w_accept};
        end
    end

    // stage 1: matrix times coordinate products
    logic signed [PW-1:0] n_pl1 [3][2];
    logic signed [PW-1:0] n_pl2 [2][2];
    logic signed [PW-1:0] r_pl1 [3][2];
    logic signed [PW-1:0] r_pl2 [2][2];
    logic signed [C-1:0]  r_xl  [2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_pl1[r][0] = PW'(w_f[r][0]) * PW'(i_item.right_x);
            n_pl1[r][1] = PW'(w_f[r][1]) * PW'(i_item.right_y);
        end
        for (int c = 0; c < 2; c++) begin
            n_pl2[c][0] = PW'(w_f[0][c]) * PW'(i_item.left_x);
            n_pl2[c][1] = PW'(w_f[1][c]) * PW'(i_item.left_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl1 <= n_pl1;
        r_pl2 <= n_pl2;
        r_xl[0] <= i_item.left_x;
        r_xl[1] <= i_item.left_y;
    end

    // stage 2: epipolar lines
    logic signed [L-1:0] n_l1 [3];
    logic signed [L-1:0] n_l2 [2];
    logic signed [L-1:0] r_l1 [3];
    logic signed [L-1:0] r_l2 [2];
    logic signed [C-1:0] r_xl2 [2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_l1[r] = L'(r_pl1[r][0]) + L'(r_pl1[r][1]) + (L'(w_f[r][2]) <<< FR);
        end
        for (int c = 0; c < 2; c++) begin
            n_l2[c] = L'(r_pl2[c][0]) + L'(r_pl2[c][1]) + (L'(w_f[2][c]) <<< FR);
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1  <= n_l1;
        r_l2  <= n_l2;
        r_xl2 <= r_xl;
    end

    // stage 3: residual partial products, line magnitudes, zero-norm flag
    logic signed [32:0]    w_lo  [2];
    logic signed [LH-1:0]  w_hi  [2];
    logic signed [L-1:0]   w_ln  [4];
    logic signed [DLO-1:0] n_dlo [2];
    logic signed [DHI-1:0] n_dhi [2];
    logic        [L-1:0]   n_abs [4];
    logic                  n_zero;
    logic signed [DLO-1:0] r_dlo [2];
    logic signed [DHI-1:0] r_dhi [2];
    logic        [L-1:0]   r_abs [4];
    logic signed [L-1:0]   r_l1z;
    logic                  r_zero;

    assign w_ln[0] = r_l1[0];
    assign w_ln[1] = r_l1[1];
    assign w_ln[2] = r_l2[0];
    assign w_ln[3] = r_l2[1];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_lo[k]  = $signed({1'b0, r_l1[k][31:0]});
            w_hi[k]  = $signed(r_l1[k][L-1:32]);
            n_dlo[k] = DLO'(r_xl2[k]) * DLO'(w_lo[k]);
            n_dhi[k] = DHI'(r_xl2[k]) * DHI'(w_hi[k]);
        end
        for (int k = 0; k < 4; k++) begin
            n_abs[k] = w_ln[k][L-1] ? (~w_ln[k] + 1'b1) : w_ln[k];
        end
        n_zero = ((r_l1[0] == '0) && (r_l1[1] == '0)) ||
                 ((r_l2[0] == '0) && (r_l2[1] == '0));
    end

    always_ff @(posedge i_clk) begin
        r_dlo  <= n_dlo;
        r_dhi  <= n_dhi;
        r_abs  <= n_abs;
        r_l1z  <= r_l1[2];
        r_zero <= n_zero;
    end

    // stage 4: residual, stage 5: its magnitude
    logic signed [D-1:0] n_d;
    logic signed [D-1:0] r_d;
    logic        [D-1:0] r_dabs;

    assign n_d = (D'(r_dhi[0]) <<< 32) + D'(r_dlo[0]) +
                 (D'(r_dhi[1]) <<< 32) + D'(r_dlo[1]) +
                 (D'(r_l1z) <<< FR);

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_dabs <= r_d[D-1] ? (~r_d + 1'b1) : r_d;
    end

    // line norms
    logic [2*L-1:0] w_sq [4];

    for (genvar k = 0; k < 4; k++) begin : g_sq
        eit_mul #(.WA(L), .WB(L)) u_sq (
            .i_clk (i_clk),
            .i_a   (r_abs[k]),
            .i_b   (r_abs[k]),
            .o_p   (w_sq[k])
        );
    end

    logic [N-1:0]  r_n1;
    logic [N-1:0]  r_n2;
    logic [NS-1:0] r_nsum;

    always_ff @(posedge i_clk) begin
        r_n1   <= N'(w_sq[0]) + N'(w_sq[1]);
        r_n2   <= N'(w_sq[2]) + N'(w_sq[3]);
        r_nsum <= NS'(r_n1) + NS'(r_n2);
    end

    logic [NP-1:0] w_np;
    logic [D2-1:0] w_d2;

    eit_mul #(.WA(N), .WB(N)) u_nprod (
        .i_clk (i_clk),
        .i_a   (r_n1),
        .i_b   (r_n2),
        .o_p   (w_np)
    );

    eit_mul #(.WA(D), .WB(D)) u_dsq (
        .i_clk (i_clk),
        .i_a   (r_dabs),
        .i_b   (r_dabs),
        .o_p   (w_d2)
    );

    // left side: d^2 * (n1 + n2) * 25600
    logic [D2-1:0] w_d2_j;
    logic [NS-1:0] w_nsum_j;
    logic [LR-1:0] w_lr;
    logic [LHS-1:0] r_lhs;

    eit_dly #(.W(D2), .DEPTH(TJ - TD2)) u_d2_dly (
        .i_clk (i_clk),
        .i_d   (w_d2),
        .o_q   (w_d2_j)
    );

    eit_dly #(.W(NS), .DEPTH(TJ - TN - 1)) u_nsum_dly (
        .i_clk (i_clk),
        .i_d   (r_nsum),
        .o_q   (w_nsum_j)
    );

    eit_mul #(.WA(D2), .WB(NS)) u_lhs (
        .i_clk (i_clk),
        .i_a   (w_d2_j),
        .i_b   (w_nsum_j),
        .o_p   (w_lr)
    );

    always_ff @(posedge i_clk) begin
        r_lhs <= (LHS'(w_lr) << 14) + (LHS'(w_lr) << 13) + (LHS'(w_lr) << 10);
    end

    // right side: t^2 * n1 * n2 * 384
    logic [RR-1:0]  w_rr;
    logic [RHS-1:0] r_rhs;

    eit_mul #(.WA(NP), .WB(TW)) u_rhs (
        .i_clk (i_clk),
        .i_a   (w_np),
        .i_b   (r_t2),
        .o_p   (w_rr)
    );

    always_ff @(posedge i_clk) begin
        r_rhs <= (RHS'(w_rr) << 8) + (RHS'(w_rr) << 7);
    end

    // compare
    logic [LHS-1:0] w_lhs_c;
    logic [RHS-1:0] w_rhs_c;
    logic           w_zero_c;
    logic           r_inl;
    logic [eit_pkg::INDEX_W-1:0] w_idx;

    eit_dly #(.W(LHS), .DEPTH(TC - TL)) u_lhs_dly (
        .i_clk (i_clk),
        .i_d   (r_lhs),
        .o_q   (w_lhs_c)
    );

    eit_dly #(.W(RHS), .DEPTH(TC - TR)) u_rhs_dly (
        .i_clk (i_clk),
        .i_d   (r_rhs),
        .o_q   (w_rhs_c)
    );

    eit_dly #(.W(1), .DEPTH(TC - 3)) u_zero_dly (
        .i_clk (i_clk),
        .i_d   (r_zero),
        .o_q   (w_zero_c)
    );

    eit_dly #(.W(eit_pkg::INDEX_W), .DEPTH(LAT)) u_idx_dly (
        .i_clk (i_clk),
        .i_d   (i_item.point_index),
        .o_q   (w_idx)
    );

    always_ff @(posedge i_clk) begin
        r_inl <= !w_zero_c && (CW'(w_lhs_c) < CW'(w_rhs_c));
    end

    assign o_strobe           = r_vld[LAT];
    assign o_result.is_inlier = r_inl;
    assign o_result.index_out = w_idx;

`ifndef SYNTHESIS
    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, LAT))
        else $error("result strobe without matching item");

    a_index_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.index_out == $past(i_item.point_index, LAT)))
        else $error("index echo misaligned");

    a_inlier_needs_rhs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.is_inlier) |-> ($past(w_rhs_c) != '0))
        else $error("inlier with zero right side");
`endif

endmodule

// ===== rtl/eit_mul.sv =====
// pipelined unsigned multiplier, one 32x32 partial product per stage
module eit_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic               i_clk,
    input  logic [WA-1:0]      i_a,
    input  logic [WB-1:0]      i_b,
    output logic [WA+WB-1:0]   o_p
);

    localparam int NA = (WA + 31) / 32;
    localparam int NB = (WB + 31) / 32;
    localparam int NS = NA * NB;
    localparam int PW = WA + WB;
    localparam int AP = NA * 32;
    localparam int BP = NB * 32;

    logic [AP-1:0] r_a   [NS];
    logic [BP-1:0] r_b   [NS];
    logic [PW-1:0] r_acc [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int I = s / NB;
        localparam int J = s % NB;
        logic [AP-1:0]    a_in;
        logic [BP-1:0]    b_in;
        logic [PW-1:0]    acc_in;
        logic [63:0]      pp;
        logic [AP+BP-1:0] term;
        logic [PW-1:0]    n_acc;

        if (s == 0) begin : g_first
            assign a_in   = AP'(i_a);
            assign b_in   = BP'(i_b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[s-1];
            assign b_in   = r_b[s-1];
            assign acc_in = r_acc[s-1];
        end

        assign pp    = a_in[I*32 +: 32] * b_in[J*32 +: 32];
        assign term  = (AP+BP)'(pp) << (32 * (I + J));
        assign n_acc = acc_in + term[PW-1:0];

        always_ff @(posedge i_clk) begin
            r_a[s]   <= a_in;
            r_b[s]   <= b_in;
            r_acc[s] <= n_acc;
        end
    end

    assign o_p = r_acc[NS-1];

endmodule

// ===== rtl/eit_dly.sv =====
// fixed-length delay line for pipeline alignment
module eit_dly #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    if (DEPTH == 0) begin : g_none
        assign o_q = i_d;
    end else begin : g_line
        logic [W-1:0] r_q [DEPTH];
        always_ff @(posedge i_clk) begin
            r_q[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
        assign o_q = r_q[DEPTH-1];
    end

endmodule
